/* rtl/lcd_window_pixel_byte_formatter_defines.svh */
// Assertion macros used by the checker file of the LCD byte formatter.
`ifndef LCD_WINDOW_PIXEL_BYTE_FORMATTER_DEFINES_SVH
`define LCD_WINDOW_PIXEL_BYTE_FORMATTER_DEFINES_SVH

// Whenever the antecedent holds, the consequent holds in the same cycle.
`define LWPBF_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Whenever the antecedent holds, the consequent holds in the next cycle.
`define LWPBF_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/lwpbf_pkg.sv */
// Types and constants shared by the LCD window and pixel byte formatter.
`default_nettype none

package lwpbf_pkg;

  // Function codes of an input item; the fourth code causes no bytes.
  typedef enum logic [1:0] {
    FUNC_REGION = 2'd0,
    FUNC_FULL   = 2'd1,
    FUNC_PIXEL  = 2'd2
  } func_t;

  // Panel command bytes.
  localparam logic [7:0] CMD_COLUMN_SET = 8'h2a;
  localparam logic [7:0] CMD_ROW_SET    = 8'h2b;
  localparam logic [7:0] CMD_MEM_WRITE  = 8'h2c;

  // Byte counts of the two sequences and the width of the byte counter.
  localparam int WINDOW_BYTES = 11;
  localparam int PIXEL_BYTES  = 2;
  localparam int IDX_W        = $clog2(WINDOW_BYTES);

  // Configuration port: register indexes, address width and reset values.
  localparam int         PADDR_W          = 3;
  localparam logic       REG_PANEL_WIDTH  = 1'b0;
  localparam logic       REG_PANEL_HEIGHT = 1'b1;
  localparam logic [15:0] PANEL_WIDTH_RST  = 16'd360;
  localparam logic [15:0] PANEL_HEIGHT_RST = 16'd360;

  // One input word.
  typedef struct packed {
    logic [1:0]  func;
    logic [15:0] region_x;
    logic [15:0] region_y;
    logic [15:0] region_w;
    logic [15:0] region_h;
    logic [31:0] pixel_word;
  } in_word_t;

  // One result word: a single byte to the panel.
  typedef struct packed {
    logic [7:0] out_byte;
    logic       is_command;
    logic       last;
  } out_word_t;

  // Panel size registers, as seen by the front end.
  typedef struct packed {
    logic [15:0] panel_width;
    logic [15:0] panel_height;
  } cfg_t;

  // Kind of work queued for the back end.
  typedef enum logic {
    KIND_WINDOW = 1'b0,
    KIND_PIXEL  = 1'b1
  } kind_t;

  // Classified work. For a pixel, xs holds the RGB565 value.
  typedef struct packed {
    kind_t       kind;
    logic [15:0] xs;
    logic [15:0] xe;
    logic [15:0] ys;
    logic [15:0] ye;
  } desc_t;

endpackage

`default_nettype wire

/* rtl/lwpbf_front.sv */
// Front end: accepts input words, works out window bounds or RGB565 values.
`default_nettype none

module lwpbf_front (
  input  wire                    clk,
  input  wire                    rst,
  input  wire                    push,
  output logic                   full,
  input  lwpbf_pkg::in_word_t    item,
  input  lwpbf_pkg::cfg_t        cfg,
  output logic                   q_push,
  output lwpbf_pkg::desc_t       q_data,
  input  wire                    q_full
);
  import lwpbf_pkg::*;

  logic  stage_valid;
  desc_t stage;
  desc_t desc_next;
  logic  keep_next;
  logic  accept;

  // The stage register can take a word when it is empty or draining now.
  assign q_push = stage_valid && !q_full;
  assign full   = stage_valid && q_full;
  assign accept = push && !full;
  assign q_data = stage;

  // Classify the word and compute its descriptor.
  always_comb begin
    desc_next = '0;
    keep_next = 1'b1;
    unique case (item.func)
      FUNC_REGION: begin
        desc_next.kind = KIND_WINDOW;
        desc_next.xs   = item.region_x;
        desc_next.xe   = item.region_x + item.region_w - 16'd1;
        desc_next.ys   = item.region_y;
        desc_next.ye   = item.region_y + item.region_h - 16'd1;
      end
      FUNC_FULL: begin
        desc_next.kind = KIND_WINDOW;
        desc_next.xe   = cfg.panel_width - 16'd1;
        desc_next.ye   = cfg.panel_height - 16'd1;
      end
      FUNC_PIXEL: begin
        desc_next.kind = KIND_PIXEL;
        desc_next.xs   = {item.pixel_word[23:19], item.pixel_word[15:10],
                          item.pixel_word[7:3]};
      end
      default: begin
        // The unused code gives no bytes, so the word is dropped here.
        keep_next = 1'b0;
      end
    endcase
  end

  // Stage register in front of the queue.
  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (accept) begin
      stage_valid <= keep_next;
    end else if (q_push) begin
      stage_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      stage <= desc_next;
    end
  end

endmodule

`default_nettype wire

/* rtl/lwpbf_queue.sv */
// Short first-in first-out queue of descriptors between front and back end.
`default_nettype none

module lwpbf_queue #(
  parameter int DEPTH = 2
) (
  input  wire               clk,
  input  wire               rst,
  input  wire               wr,
  input  lwpbf_pkg::desc_t  wr_data,
  output logic              full,
  input  wire               rd,
  output lwpbf_pkg::desc_t  rd_data,
  output logic              empty
);
  import lwpbf_pkg::*;

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(DEPTH);

  desc_t            slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_wr;
  logic             do_rd;

  assign full    = (count == DEPTH_CNT);
  assign empty   = (count == '0);
  assign do_wr   = wr && !full;
  assign do_rd   = rd && !empty;
  assign rd_data = slots[rd_ptr];

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end

  // Slot storage.
  always_ff @(posedge clk) begin
    if (do_wr) begin
      slots[wr_ptr] <= wr_data;
    end
  end

endmodule

`default_nettype wire

/* rtl/lwpbf_back.sv */
// Back end: steps through the bytes of each descriptor into the result register.
`default_nettype none

module lwpbf_back (
  input  wire                    clk,
  input  wire                    rst,
  input  lwpbf_pkg::desc_t       q_data,
  input  wire                    q_empty,
  output logic                   q_pop,
  output lwpbf_pkg::out_word_t   result,
  output logic                   empty,
  input  wire                    pop
);
  import lwpbf_pkg::*;

  localparam logic [IDX_W-1:0] PIXEL_LAST = IDX_W'(PIXEL_BYTES - 1);

  desc_t            cur;
  logic             active;
  logic [IDX_W-1:0] idx;
  logic             out_valid;
  out_word_t        sel;
  logic             load_out;
  logic             item_done;

  // Byte selection for the current position in the sequence.
  always_comb begin
    sel = '0;
    if (cur.kind == KIND_PIXEL) begin
      sel.out_byte = (idx == '0) ? cur.xs[15:8] : cur.xs[7:0];
      sel.last     = (idx == PIXEL_LAST);
    end else begin
      unique case (idx)
        IDX_W'(0):  begin sel.out_byte = CMD_COLUMN_SET; sel.is_command = 1'b1; end
        IDX_W'(1):  sel.out_byte = cur.xs[15:8];
        IDX_W'(2):  sel.out_byte = cur.xs[7:0];
        IDX_W'(3):  sel.out_byte = cur.xe[15:8];
        IDX_W'(4):  sel.out_byte = cur.xe[7:0];
        IDX_W'(5):  begin sel.out_byte = CMD_ROW_SET; sel.is_command = 1'b1; end
        IDX_W'(6):  sel.out_byte = cur.ys[15:8];
        IDX_W'(7):  sel.out_byte = cur.ys[7:0];
        IDX_W'(8):  sel.out_byte = cur.ye[15:8];
        IDX_W'(9):  sel.out_byte = cur.ye[7:0];
        IDX_W'(10): begin
          sel.out_byte   = CMD_MEM_WRITE;
          sel.is_command = 1'b1;
          sel.last       = 1'b1;
        end
        default: sel = '0;
      endcase
    end
  end

  // A byte moves into the result register whenever that register frees up.
  assign load_out  = active && (!out_valid || pop);
  assign item_done = load_out && sel.last;
  assign q_pop     = !q_empty && (!active || item_done);
  assign empty     = !out_valid;

  // Sequencer and result register control.
  always_ff @(posedge clk) begin
    if (rst) begin
      active    <= 1'b0;
      idx       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (q_pop) begin
        active <= 1'b1;
        idx    <= '0;
      end else if (item_done) begin
        active <= 1'b0;
      end else if (load_out) begin
        idx <= idx + 1'b1;
      end
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur <= q_data;
    end
    if (load_out) begin
      result <= sel;
    end
  end

endmodule

`default_nettype wire

/* rtl/lcd_window_pixel_byte_formatter.sv */
// Top level of the LCD window and pixel byte formatter with its register port.
//
// Input words enter through a queue-style port: a word is taken at a rising
// edge with push high and full low. Region and full-frame words open a drawing
// window and give eleven bytes (column command, four data bytes, row command,
// four data bytes, memory-write command); a pixel word gives two RGB565 bytes.
// Results leave one byte a word: the oldest byte is on result while empty is
// low and is taken at an edge with pop high. The last flag marks the final
// byte of each input word; words with the unused function code give nothing.
// With the block otherwise empty, the first byte of a word passes the front stage,
// the queue, the back-end descriptor and the result register. The back end sends
// one byte a cycle while the receiver pops, with no gap between queued words.
// When the receiver stops popping, the result register holds its byte, the
// queue and the front stage fill, and full rises; nothing is lost.
// Reset clears the queue and all valid state and sets both panel dimensions
// to 360. The panel width is at byte address 0, the height at address 4.
`default_nettype none

module lcd_window_pixel_byte_formatter #(
  parameter int QUEUE_DEPTH = 2
) (
  input  wire                                 clk,
  input  wire                                 rst,
  input  wire                                 push,
  output logic                                full,
  input  lwpbf_pkg::in_word_t                 item,
  output logic                                empty,
  input  wire                                 pop,
  output lwpbf_pkg::out_word_t                result,
  input  wire                                 psel,
  input  wire                                 penable,
  input  wire                                 pwrite,
  input  wire [lwpbf_pkg::PADDR_W-1:0]        paddr,
  input  wire [31:0]                          pwdata,
  output logic [31:0]                         prdata,
  output logic                                pready
);
  import lwpbf_pkg::*;

  cfg_t  cfg;
  logic  cfg_wr;
  logic  reg_sel;
  logic  q_push;
  desc_t q_wr_data;
  logic  q_full;
  logic  q_pop;
  desc_t q_rd_data;
  logic  q_empty;

  // Register port: no wait states, decoded on the register-select address bit.
  assign pready  = 1'b1;
  assign reg_sel = paddr[2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_comb begin
    unique case (reg_sel)
      REG_PANEL_WIDTH:  prdata = {16'd0, cfg.panel_width};
      REG_PANEL_HEIGHT: prdata = {16'd0, cfg.panel_height};
      default:          prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.panel_width  <= PANEL_WIDTH_RST;
      cfg.panel_height <= PANEL_HEIGHT_RST;
    end else if (cfg_wr) begin
      unique case (reg_sel)
        REG_PANEL_WIDTH:  cfg.panel_width  <= pwdata[15:0];
        REG_PANEL_HEIGHT: cfg.panel_height <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  // Front end, queue and back end.
  lwpbf_front u_front (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .full   (full),
    .item   (item),
    .cfg    (cfg),
    .q_push (q_push),
    .q_data (q_wr_data),
    .q_full (q_full)
  );

  lwpbf_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr      (q_push),
    .wr_data (q_wr_data),
    .full    (q_full),
    .rd      (q_pop),
    .rd_data (q_rd_data),
    .empty   (q_empty)
  );

  lwpbf_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_data  (q_rd_data),
    .q_empty (q_empty),
    .q_pop   (q_pop),
    .result  (result),
    .empty   (empty),
    .pop     (pop)
  );

endmodule

`default_nettype wire

/* rtl/lwpbf_checker.sv */
// Port-level checker for the LCD byte formatter and its bind to the top level.
`default_nettype none
`include "lcd_window_pixel_byte_formatter_defines.svh"

module lwpbf_checker (
  input wire                   clk,
  input wire                   rst,
  input wire                   empty,
  input wire                   pop,
  input lwpbf_pkg::out_word_t  result
);
  import lwpbf_pkg::*;

  // A byte that is not taken stays on the ports unchanged.
  `LWPBF_ASSERT_NEXT(a_hold, clk, rst, !empty && !pop, !empty && $stable(result), "result changed while stalled")

  // Only the three panel commands are ever flagged as commands.
  `LWPBF_ASSERT_SAME(a_cmd_code, clk, rst, !empty && result.is_command, result.out_byte == CMD_COLUMN_SET || result.out_byte == CMD_ROW_SET || result.out_byte == CMD_MEM_WRITE, "unknown command byte")

  // The address commands never end a word; the memory-write command always does.
  `LWPBF_ASSERT_SAME(a_cmd_last, clk, rst, !empty && result.is_command, result.last == (result.out_byte == CMD_MEM_WRITE), "wrong last flag on command")

  // A column command is always followed by data.
  `LWPBF_ASSERT_NEXT(a_col_data, clk, rst, !empty && pop && result.is_command && result.out_byte == CMD_COLUMN_SET, empty || !result.is_command, "column command not followed by data")

endmodule

bind lcd_window_pixel_byte_formatter lwpbf_checker u_checker (.*);

`default_nettype wire

/* test/lcd_window_pixel_byte_formatter_tb.sv */
// Self-checking testbench for the LCD window and pixel byte formatter.
`default_nettype none

module lcd_window_pixel_byte_formatter_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import lwpbf_pkg::*;

  // The function code that gives no bytes at all.
  localparam logic [1:0] FUNC_UNUSED = 2'd3;
  // Cycles waited after the last expected byte so that the block can settle.
  localparam int SETTLE_CYCLES = 8;
  // Longest wait for outstanding bytes before they are declared lost.
  localparam int DRAIN_LIMIT = 5000;
  // Mismatch lines printed before further ones are only counted.
  localparam int PRINT_LIMIT = 40;
  localparam int IDLE_PCT = 36;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                push = 1'b0;
  logic                full;
  in_word_t            item = '0;
  logic                empty;
  logic                pop = 1'b0;
  out_word_t           result;
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [PADDR_W-1:0]  paddr = '0;
  logic [31:0]         pwdata = '0;
  logic [31:0]         prdata;
  logic                pready;

  // Testbench copy of the panel size registers.
  logic [15:0] panel_w = PANEL_WIDTH_RST;
  logic [15:0] panel_h = PANEL_HEIGHT_RST;

  // Bytes the block still owes, oldest first.
  out_word_t   byte_q[$];
  int          err_count = 0;
  // When set, neither side idles.
  bit          steady = 1'b0;

  lcd_window_pixel_byte_formatter u_top (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .full    (full),
    .item    (item),
    .empty   (empty),
    .pop     (pop),
    .result  (result),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Clock with a 2 ns period.
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Prints one mismatch line (up to a limit) and counts it.
  task automatic report(input string msg);
    err_count++;
    if (err_count <= PRINT_LIMIT) begin
      $display("%0t ns: mismatch: %s", $realtime, msg);
    end
  endtask

  // Queues one expected byte.
  task automatic queue_byte(input logic [7:0] b, input logic cmd, input logic fin);
    out_word_t w;
    w.out_byte   = b;
    w.is_command = cmd;
    w.last       = fin;
    byte_q.push_back(w);
  endtask

  // Queues the eleven bytes that open a window; the ends wrap at 16 bits.
  task automatic queue_window(input logic [15:0] xs, input logic [15:0] ys,
                              input logic [15:0] w, input logic [15:0] h);
    logic [15:0] xe;
    logic [15:0] ye;
    xe = xs + w - 16'd1;
    ye = ys + h - 16'd1;
    queue_byte(CMD_COLUMN_SET, 1'b1, 1'b0);
    queue_byte(xs[15:8], 1'b0, 1'b0);
    queue_byte(xs[7:0], 1'b0, 1'b0);
    queue_byte(xe[15:8], 1'b0, 1'b0);
    queue_byte(xe[7:0], 1'b0, 1'b0);
    queue_byte(CMD_ROW_SET, 1'b1, 1'b0);
    queue_byte(ys[15:8], 1'b0, 1'b0);
    queue_byte(ys[7:0], 1'b0, 1'b0);
    queue_byte(ye[15:8], 1'b0, 1'b0);
    queue_byte(ye[7:0], 1'b0, 1'b0);
    queue_byte(CMD_MEM_WRITE, 1'b1, 1'b1);
  endtask

  // Works out the bytes that one accepted input word gives.
  task automatic predict_bytes(input in_word_t w);
    logic [31:0] v;
    v = w.pixel_word;
    case (w.func)
      FUNC_REGION: begin
        queue_window(w.region_x, w.region_y, w.region_w, w.region_h);
      end
      FUNC_FULL: begin
        queue_window(16'd0, 16'd0, panel_w, panel_h);
      end
      FUNC_PIXEL: begin
        // RGB565: red 5 bits, green 6 bits, blue 5 bits; top byte ignored.
        queue_byte({v[23:19], v[15:13]}, 1'b0, 1'b0);
        queue_byte({v[12:10], v[7:3]}, 1'b0, 1'b1);
      end
      default: begin
      end
    endcase
  endtask

  // Sends one input word, idling first at random; push is left high.
  task automatic send_word(input in_word_t w);
    @(negedge clk);
    while (!steady && $urandom_range(99) < IDLE_PCT) begin
      push = 1'b0;
      item = in_word_t'({$urandom, $urandom, $urandom});
      @(negedge clk);
    end
    push = 1'b1;
    item = w;
    do @(posedge clk); while (full);
    predict_bytes(w);
  endtask

  // Lowers push once the last word has been taken.
  task automatic stop_pushing;
    @(negedge clk);
    push = 1'b0;
  endtask

  // Waits until every expected byte has come, then lets the block settle.
  task automatic wait_drained;
    int n;
    n = 0;
    while (byte_q.size() != 0 && n < DRAIN_LIMIT) begin
      @(posedge clk);
      n++;
    end
    if (byte_q.size() != 0) begin
      report($sformatf("%0d expected bytes never came", byte_q.size()));
      byte_q.delete();
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // One register write: setup cycle, then access cycle.
  task automatic write_reg(input logic reg_idx, input logic [15:0] value);
    @(negedge clk);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = {reg_idx, 2'b00};
    // Upper bits are random; only the low half word is stored.
    pwdata  = {16'($urandom_range(16'hffff)), value};
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    if (reg_idx == REG_PANEL_WIDTH) begin
      panel_w = value;
    end else begin
      panel_h = value;
    end
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  // Changes the panel size once the block has gone idle.
  task automatic set_panel(input logic [15:0] w, input logic [15:0] h);
    stop_pushing();
    wait_drained();
    write_reg(REG_PANEL_WIDTH, w);
    write_reg(REG_PANEL_HEIGHT, h);
  endtask

  // Builds a word of the given function with random content everywhere.
  function automatic in_word_t rand_word(input logic [1:0] f);
    in_word_t w;
    w = in_word_t'({$urandom, $urandom, $urandom});
    w.func = f;
    return w;
  endfunction

  // Picks a region coordinate, often one at the edge of the range.
  function automatic logic [15:0] rand_coord;
    case ($urandom_range(7))
      0: return 16'h0000;
      1: return 16'h0001;
      2: return 16'hffff;
      3: return 16'hfffe;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic in_word_t rand_region;
    in_word_t w;
    w = rand_word(FUNC_REGION);
    w.region_x = rand_coord();
    w.region_y = rand_coord();
    w.region_w = rand_coord();
    w.region_h = rand_coord();
    return w;
  endfunction

  function automatic in_word_t rand_any;
    int r;
    r = $urandom_range(99);
    if (r < 40) return rand_word(FUNC_PIXEL);
    if (r < 65) return rand_region();
    if (r < 85) return rand_word(FUNC_FULL);
    return rand_word(FUNC_UNUSED);
  endfunction

  // Full-frame window with the panel size left at its reset value.
  task automatic test_reset_panel;
    send_word(rand_word(FUNC_FULL));
  endtask

  // Region windows at the edges, including the wrap of the end values.
  task automatic test_region_edges;
    logic [15:0] edges [6][4];
    in_word_t w;
    edges = '{'{16'h0000, 16'h0000, 16'h0000, 16'h0000},
              '{16'hffff, 16'hffff, 16'hffff, 16'hffff},
              '{16'hffff, 16'h0000, 16'h0001, 16'h0001},
              '{16'h0000, 16'hffff, 16'hffff, 16'h0002},
              '{16'h1234, 16'h00ef, 16'h0100, 16'h00f0},
              '{16'h8000, 16'h7fff, 16'h8000, 16'h8001}};
    foreach (edges[i]) begin
      w = rand_word(FUNC_REGION);
      w.region_x = edges[i][0];
      w.region_y = edges[i][1];
      w.region_w = edges[i][2];
      w.region_h = edges[i][3];
      send_word(w);
    end
  endtask

  // Pixel conversion on all-zero, all-one and striped words.
  task automatic test_pixel_edges;
    logic [31:0] pix [5];
    in_word_t w;
    pix = '{32'h0000_0000, 32'hffff_ffff, 32'h00ff_ffff, 32'hff00_0000, 32'h5aa5_5aa5};
    foreach (pix[i]) begin
      w = rand_word(FUNC_PIXEL);
      w.pixel_word = pix[i];
      send_word(w);
    end
  endtask

  // The unused function code gives nothing, even between other words.
  task automatic test_unused_func;
    send_word(rand_word(FUNC_UNUSED));
    send_word(rand_word(FUNC_PIXEL));
    send_word(rand_word(FUNC_UNUSED));
  endtask

  // Full-frame windows at the extreme panel sizes, zero included.
  task automatic test_panel_extremes;
    set_panel(16'd1, 16'hffff);
    send_word(rand_word(FUNC_FULL));
    set_panel(16'hffff, 16'd1);
    send_word(rand_word(FUNC_FULL));
    set_panel(16'd0, 16'd0);
    send_word(rand_word(FUNC_FULL));
    send_word(rand_word(FUNC_PIXEL));
  endtask

  // Random words in several panel settings, with one full pause midway.
  task automatic test_random_mix;
    logic [15:0] sizes [4][2];
    sizes = '{'{PANEL_WIDTH_RST, PANEL_HEIGHT_RST},
              '{16'hffff, 16'hffff},
              '{16'($urandom_range(1, 16'hffff)), 16'($urandom_range(1, 16'hffff))},
              '{16'd1, 16'd1}};
    foreach (sizes[p]) begin
      set_panel(sizes[p][0], sizes[p][1]);
      for (int i = 0; i < 80; i++) begin
        send_word(rand_any());
        if (p == 1 && i == 40) begin
          stop_pushing();
          wait_drained();
        end
      end
    end
  endtask

  // A stretch with neither side idling: pixels back to back, then windows.
  task automatic test_steady_stream;
    steady = 1'b1;
    for (int i = 0; i < 20; i++) begin
      send_word(rand_word(FUNC_PIXEL));
    end
    for (int i = 0; i < 4; i++) begin
      send_word(i[0] ? rand_word(FUNC_FULL) : rand_region());
    end
    stop_pushing();
    wait_drained();
    steady = 1'b0;
  endtask

  // Receiver: pops at random, or always during a steady stretch.
  always @(negedge clk) begin
    pop = steady || ($urandom_range(99) >= IDLE_PCT);
  end

  // Compares each byte taken with the oldest expected one.
  always @(posedge clk) begin
    out_word_t want;
    if (!rst && pop && !empty) begin
      if (byte_q.size() == 0) begin
        report($sformatf("unexpected byte %02h cmd %0b last %0b",
                         result.out_byte, result.is_command, result.last));
      end else begin
        want = byte_q.pop_front();
        if (result.out_byte !== want.out_byte) begin
          report($sformatf("out_byte %02h, expected %02h", result.out_byte, want.out_byte));
        end
        if (result.is_command !== want.is_command) begin
          report($sformatf("is_command %0b, expected %0b on byte %02h",
                           result.is_command, want.is_command, want.out_byte));
        end
        if (result.last !== want.last) begin
          report($sformatf("last %0b, expected %0b on byte %02h",
                           result.last, want.last, want.out_byte));
        end
      end
    end
  end

  // Main sequence.
  initial begin
    repeat (2) @(negedge clk);
    rst = 1'b0;
    test_reset_panel();
    test_region_edges();
    test_pixel_edges();
    test_unused_func();
    test_panel_extremes();
    test_steady_stream();
    test_random_mix();
    stop_pushing();
    wait_drained();
    if (err_count == 0) begin
      $display("lcd_window_pixel_byte_formatter_tb: done, clean");
    end else begin
      $display("lcd_window_pixel_byte_formatter_tb: done, errors");
    end
    $finish;
  end

  // Watchdog against a hung handshake.
  initial begin
    #2_000_000;
    $display("lcd_window_pixel_byte_formatter_tb: done, errors");
    $finish;
  end

endmodule

`default_nettype wire
